>>> sv/rdce_pkg.sv
// shared types, constants and helper functions of the run-length encoder
`timescale 1ns / 1ps

package rdce_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int LEN_W = (COUNT_WIDTH < 16) ? COUNT_WIDTH : 16;
	localparam logic [LEN_W-1:0] CNT_MAX = {LEN_W{1'b1}};
	localparam int DIG_W = 17;
	localparam int POS_W = 3;
	localparam int Q_DEPTH = 4;
	localparam int Q_AW = $clog2(Q_DEPTH);
	localparam int Q_CW = $clog2(Q_DEPTH + 1);
	localparam logic [15:0] LIMIT_RESET = 16'hFFFF;
	localparam logic [7:0] ASCII_ZERO = 8'h30;

	typedef struct packed {
		logic [7:0] sym;
		logic [LEN_W-1:0] len;
		logic [POS_W-1:0] pos;
		logic last;
		logic done;
	} rec_t;

	typedef struct packed {
		logic a_valid;
		logic b_valid;
		rec_t a;
		rec_t b;
	} push_t;

	typedef struct packed {
		logic not_empty;
		logic room2;
		logic [Q_CW-1:0] count;
	} qstat_t;

	function automatic logic [DIG_W-1:0] place_mult(logic [POS_W-1:0] pos, int k);
		logic [DIG_W-1:0] r;
		case (pos)
			3'd0: r = DIG_W'(k);
			3'd1: r = DIG_W'(k * 10);
			3'd2: r = DIG_W'(k * 100);
			3'd3: r = DIG_W'(k * 1000);
			3'd4: r = DIG_W'(k * 10000);
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [POS_W-1:0] top_pos(logic [LEN_W-1:0] len);
		logic [DIG_W-1:0] v;
		logic [POS_W-1:0] p;
		v = DIG_W'(len);
		if (v >= DIG_W'(10000)) p = POS_W'(4);
		else if (v >= DIG_W'(1000)) p = POS_W'(3);
		else if (v >= DIG_W'(100)) p = POS_W'(2);
		else if (v >= DIG_W'(10)) p = POS_W'(1);
		else p = POS_W'(0);
		return p;
	endfunction

	function automatic logic [LEN_W-1:0] eff_limit(logic [15:0] v);
		logic [LEN_W-1:0] r;
		if (v == 16'd0) r = LEN_W'(1);
		else if (DIG_W'(v) > DIG_W'(CNT_MAX)) r = CNT_MAX;
		else r = LEN_W'(v);
		return r;
	endfunction

endpackage

>>> sv/rdce_front.sv
// front end: takes input bytes, tracks the open run and queues finished runs
`timescale 1ns / 1ps

module rdce_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [15:0]          cfg_wr_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,
	input  logic                 s_tlast,
	input  rdce_pkg::qstat_t     qstat,
	output rdce_pkg::push_t      push
);

	logic [rdce_pkg::LEN_W-1:0] lim_q;
	logic [7:0]                 sym_q;
	logic [rdce_pkg::LEN_W-1:0] len_q;
	logic                       open_q;

	logic                       acc;
	logic                       cont;
	logic [7:0]                 upd_sym;
	logic [rdce_pkg::LEN_W-1:0] upd_len;

	assign s_tready = qstat.room2;
	assign acc = s_tvalid && s_tready;

	always_comb begin
		cont = open_q && (s_tdata == sym_q) && (len_q < lim_q);
		upd_sym = cont ? sym_q : s_tdata;
		upd_len = cont ? (len_q + rdce_pkg::LEN_W'(1)) : rdce_pkg::LEN_W'(1);

		push.a_valid = acc && open_q && !cont;
		push.a.sym = sym_q;
		push.a.len = len_q;
		push.a.pos = rdce_pkg::top_pos(len_q);
		push.a.last = !s_tlast;
		push.a.done = 1'b0;

		push.b_valid = acc && s_tlast;
		push.b.sym = upd_sym;
		push.b.len = upd_len;
		push.b.pos = rdce_pkg::top_pos(upd_len);
		push.b.last = 1'b1;
		push.b.done = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= rdce_pkg::eff_limit(rdce_pkg::LIMIT_RESET);
			sym_q <= '0;
			len_q <= '0;
			open_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				lim_q <= rdce_pkg::eff_limit(cfg_wr_data);
			end
			if (acc) begin
				if (s_tlast) begin
					open_q <= 1'b0;
					sym_q <= '0;
					len_q <= '0;
				end else begin
					open_q <= 1'b1;
					sym_q <= upd_sym;
					len_q <= upd_len;
				end
			end
		end
	end

endmodule

>>> sv/rdce_queue.sv
// short run queue between front and back, up to two pushes per cycle
`timescale 1ns / 1ps

module rdce_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  rdce_pkg::push_t    push,
	input  logic               pop,
	output rdce_pkg::rec_t     head,
	output rdce_pkg::qstat_t   qstat
);

	rdce_pkg::rec_t              mem_q [rdce_pkg::Q_DEPTH];
	logic [rdce_pkg::Q_AW-1:0]   wr_q;
	logic [rdce_pkg::Q_AW-1:0]   rd_q;
	logic [rdce_pkg::Q_CW-1:0]   cnt_q;
	logic [rdce_pkg::Q_AW-1:0]   wr_b;
	logic [rdce_pkg::Q_CW-1:0]   n_push;

	always_comb begin
		wr_b = wr_q + rdce_pkg::Q_AW'(push.a_valid);
		n_push = rdce_pkg::Q_CW'(push.a_valid) + rdce_pkg::Q_CW'(push.b_valid);
		head = mem_q[rd_q];
		qstat.not_empty = (cnt_q != '0);
		qstat.room2 = (cnt_q <= rdce_pkg::Q_CW'(rdce_pkg::Q_DEPTH - 2));
		qstat.count = cnt_q;
	end

	always_ff @(posedge clk) begin
		if (push.a_valid) begin
			mem_q[wr_q] <= push.a;
		end
		if (push.b_valid) begin
			mem_q[wr_b] <= push.b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + rdce_pkg::Q_AW'(n_push);
			if (pop) begin
				rd_q <= rd_q + rdce_pkg::Q_AW'(1);
			end
			cnt_q <= cnt_q + n_push - rdce_pkg::Q_CW'(pop);
		end
	end

endmodule

>>> sv/rdce_back.sv
// back end: turns queued runs into a symbol byte and decimal count digits
`timescale 1ns / 1ps

module rdce_back (
	input  logic               clk,
	input  logic               arst_n,
	input  rdce_pkg::rec_t     head,
	input  rdce_pkg::qstat_t   qstat,
	output logic               pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,
	output logic               m_tlast,
	output logic               m_tuser
);

	logic                         out_valid_q;
	logic [7:0]                   out_byte_q;
	logic                         out_last_q;
	logic                         out_done_q;
	logic                         busy_q;
	logic [rdce_pkg::LEN_W-1:0]   rem_q;
	logic [rdce_pkg::POS_W-1:0]   pos_q;
	logic                         rec_last_q;
	logic                         rec_done_q;

	logic                         can_load;
	logic                         step;
	logic [3:0]                   dig;
	logic [rdce_pkg::DIG_W-1:0]   sub;

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_byte_q;
	assign m_tlast = out_last_q;
	assign m_tuser = out_done_q;

	always_comb begin
		can_load = !out_valid_q || m_tready;
		pop = can_load && !busy_q && qstat.not_empty;
		step = can_load && busy_q;
		dig = '0;
		sub = '0;
		for (int k = 1; k < 10; k++) begin
			if (rdce_pkg::DIG_W'(rem_q) >= rdce_pkg::place_mult(pos_q, k)) begin
				dig = 4'(k);
				sub = rdce_pkg::place_mult(pos_q, k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			busy_q <= 1'b0;
		end else if (can_load) begin
			out_valid_q <= pop || step;
			if (pop) begin
				busy_q <= 1'b1;
			end else if (step) begin
				busy_q <= (pos_q != '0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_byte_q <= head.sym;
			out_last_q <= 1'b0;
			out_done_q <= 1'b0;
			rem_q <= head.len;
			pos_q <= head.pos;
			rec_last_q <= head.last;
			rec_done_q <= head.done;
		end else if (step) begin
			out_byte_q <= rdce_pkg::ASCII_ZERO + {4'b0000, dig};
			out_last_q <= (pos_q == '0) && rec_last_q;
			out_done_q <= (pos_q == '0) && rec_done_q;
			rem_q <= rdce_pkg::LEN_W'(rdce_pkg::DIG_W'(rem_q) - sub);
			pos_q <= pos_q - rdce_pkg::POS_W'(1);
		end
	end

endmodule

>>> sv/rle_decimal_count_encoder_core.sv
// top level of the run-length encoder with decimal counts
// throughput: one result byte per cycle from the back end output register while m_tready is high;
// an input request is taken every cycle while the run queue has room for two runs; when every
// byte ends a run, each one yields two result bytes (symbol plus one digit)
// reset: arst_n clears the open run, the run queue and the output; run_limit returns to 65535
`timescale 1ns / 1ps

module rle_decimal_count_encoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,   // run_limit
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,       // data_byte
	input  logic        s_tlast,       // end_of_stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,       // code_byte
	output logic        m_tlast,       // last_of_burst
	output logic        m_tuser        // stream_done
);

	rdce_pkg::push_t  push;
	rdce_pkg::qstat_t qstat;
	rdce_pkg::rec_t   head;
	logic             pop;

	rdce_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.qstat       (qstat),
		.push        (push)
	);

	rdce_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	rdce_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.qstat    (qstat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

`ifndef SYNTH
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast)
		else $error("stream_done without last_of_burst");

	a_flush_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> qstat.not_empty)
		else $error("end of stream request left no run queued");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.count <= rdce_pkg::Q_CW'(rdce_pkg::Q_DEPTH))
		else $error("run queue overflow");
`endif

endmodule

>>> sim/tb.sv
// testbench of the run-length encoder with decimal counts, self-checking against its own predictor
`timescale 1ns / 1ps

module tb;

	typedef struct {
		logic [7:0] data;
		logic       eos;
	} src_t;

	typedef struct {
		logic [7:0] code;
		logic       last;
		logic       done;
	} code_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = 16'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;       // data_byte
	logic        s_tlast = 1'b0;       // end_of_stream
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;              // code_byte
	logic        m_tlast;              // last_of_burst
	logic        m_tuser;              // stream_done

	src_t  src_q[$];
	code_t code_q[$];
	int    queued_total = 0;
	int    taken_total = 0;
	int    err_cnt = 0;
	int    hold_req = 0;
	logic  in_fire = 1'b0;

	// encoder state as seen by the predictor
	logic [15:0] run_limit_q = 16'hFFFF;
	logic [7:0]  run_sym = 8'd0;
	int unsigned run_len = 0;
	logic        run_open = 1'b0;

	rle_decimal_count_encoder_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("tb: done, errors");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		err_cnt++;
		if (err_cnt <= 10) begin
			$display("tb: %s", what);
		end
	endtask

	task automatic put_run(input logic [7:0] sym, input int unsigned len);
		int unsigned digit[5];
		int          nd;
		int unsigned v;
		code_t       c;
		c.code = sym;
		c.last = 1'b0;
		c.done = 1'b0;
		code_q.push_back(c);
		v = len;
		nd = 0;
		do begin
			digit[nd] = v % 10;
			nd++;
			v = v / 10;
		end while (v != 0 && nd < 5);
		while (nd > 0) begin
			nd--;
			c.code = rdce_pkg::ASCII_ZERO + 8'(digit[nd]);
			code_q.push_back(c);
		end
	endtask

	task automatic encode_step(input logic [7:0] b, input logic eos);
		int unsigned lim_eff;
		int          n_prev;
		n_prev = code_q.size();
		lim_eff = (run_limit_q == 16'd0) ? 1 : run_limit_q;
		if (lim_eff > rdce_pkg::CNT_MAX) begin
			lim_eff = rdce_pkg::CNT_MAX;
		end
		if (run_open && b == run_sym && run_len < lim_eff) begin
			run_len++;
		end else begin
			if (run_open) begin
				put_run(run_sym, run_len);
			end
			run_sym = b;
			run_len = 1;
			run_open = 1'b1;
		end
		if (eos) begin
			put_run(run_sym, run_len);
			run_open = 1'b0;
			run_sym = 8'd0;
			run_len = 0;
		end
		if (code_q.size() > n_prev) begin
			code_q[code_q.size() - 1].last = 1'b1;
			code_q[code_q.size() - 1].done = eos;
		end
	endtask

	// output check first, then prediction of the request taken at this edge
	always @(posedge clk) begin : mon
		code_t c;
		if (cfg_wr_en) begin
			run_limit_q = cfg_wr_data;
		end
		if (m_tvalid && m_tready) begin
			if (code_q.size() == 0) begin
				flag_mismatch($sformatf("unexpected output %02h/%0b/%0b", m_tdata, m_tlast, m_tuser));
			end else begin
				c = code_q.pop_front();
				if (m_tdata !== c.code || m_tlast !== c.last || m_tuser !== c.done) begin
					flag_mismatch($sformatf("mismatch exp %02h/%0b/%0b got %02h/%0b/%0b",
						c.code, c.last, c.done, m_tdata, m_tlast, m_tuser));
				end
			end
		end
		if (s_tvalid && s_tready) begin
			encode_step(s_tdata, s_tlast);
			taken_total++;
		end
		in_fire <= s_tvalid && s_tready;
	end

	// sender: bursts of random length with random gaps
	always @(negedge clk) begin : drv
		int   burst_left;
		int   gap_left;
		src_t it;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			burst_left = 1;
			gap_left = 0;
		end else if (!s_tvalid || in_fire) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (src_q.size() > 0) begin
				it = src_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= it.data;
				s_tlast <= it.eos;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
						: $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: own stall pattern plus a long hold-off on request
	always @(negedge clk) begin : rcv
		int hold_left;
		int hold_ack;
		int rx_cyc;
		int rx_mode;
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left = 0;
			hold_ack = 0;
			rx_cyc = 0;
			rx_mode = 0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_ack != hold_req) begin
			hold_ack = hold_req;
			hold_left = 400;
			m_tready <= 1'b0;
		end else begin
			if (rx_cyc % 96 == 0) begin
				rx_mode = $urandom_range(0, 3);
			end
			rx_cyc++;
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 3) != 0);
				default: m_tready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	task automatic add(input logic [7:0] b, input logic eos);
		src_t it;
		it.data = b;
		it.eos = eos;
		src_q.push_back(it);
		queued_total++;
	endtask

	task automatic add_run(input logic [7:0] b, input int n, input logic eos);
		for (int i = 0; i < n; i++) begin
			add(b, eos && i == n - 1);
		end
	endtask

	task automatic drain();
		while (taken_total != queued_total || code_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
	endtask

	task automatic set_limit(input logic [15:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic gen_phase(input int n);
		int         made;
		int         k;
		int         len;
		logic [7:0] sym;
		logic       ends;
		made = 0;
		while (made < n) begin
			k = $urandom_range(0, 99);
			if (k < 10) begin
				add(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
				made++;
			end else begin
				sym = $urandom_range(0, 1) ? 8'h61 + 8'($urandom_range(0, 3))
					: 8'($urandom_range(0, 255));
				k = $urandom_range(0, 99);
				len = (k < 70) ? $urandom_range(1, 4)
					: (k < 95) ? $urandom_range(5, 15) : $urandom_range(16, 120);
				ends = ($urandom_range(0, 6) == 0);
				add_run(sym, len, ends);
				made += len;
			end
		end
		if ($urandom_range(0, 1)) begin
			add(8'($urandom_range(0, 255)), 1'b1);
		end
	endtask

	initial begin : stim
		logic [15:0] lim_set[8];
		logic [7:0]  prev;
		logic [7:0]  nxt;
		lim_set = '{16'd1, 16'd2, 16'd3, 16'd9, 16'd10, 16'd100, 16'd0, 16'hFFFF};
		lim_set[6] = 16'($urandom_range(0, 65535));
		arst_n = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// reset limit: single byte streams, short runs, new stream after the end
		add(8'h00, 1'b1);
		add_run(8'hFF, 3, 1'b0);
		add_run(8'h41, 2, 1'b1);
		add_run(8'h55, 12, 1'b0);
		add(8'hAA, 1'b1);
		add_run(8'h00, 2, 1'b1);
		// three digit count
		add_run(8'h51, 100, 1'b0);
		add_run(8'h52, 10, 1'b1);
		drain();

		// zero limit behaves as one
		set_limit(16'd0);
		add_run(8'h33, 3, 1'b0);
		add(8'h34, 1'b1);
		drain();

		// limit split of a long run
		set_limit(16'd10);
		add_run(8'h7E, 25, 1'b1);
		drain();

		// receiver holds off while alternating bytes fill the block
		set_limit(16'd2);
		hold_req++;
		prev = 8'h00;
		for (int i = 0; i < 40; i++) begin
			nxt = 8'($urandom_range(0, 255));
			if (nxt == prev) begin
				nxt = ~prev;
			end
			add(nxt, i == 39);
			prev = nxt;
		end
		drain();

		foreach (lim_set[i]) begin
			set_limit(lim_set[i]);
			gen_phase(16);
			drain();
		end

		if (err_cnt == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule
